// ----- sv/gha_pkg.sv -----
`timescale 1ns / 1ps
// gha_pkg: shared constants, codes and types of the generational handle allocator
// used by every file of the block but gha_ram; depends on nothing

package gha_pkg;

  // default geometry
  localparam int unsigned SLOTS_DEF    = 1024;
  localparam int unsigned GEN_BITS_DEF = 16;

  // fixed field widths of the channel words
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned STATUS_W = 2;

  // command codes; any other code acts as a check
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // request word
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] handle_generation;
  } req_t;

  // response word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [GEN_W-1:0]    granted_generation;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;          // request word accepted, reads issued
    logic pop;           // stack word is on the read port
    logic grant;         // slot word of a popped slot is on the read port
    logic check;         // slot word of a handle is on the read port
    logic direct;        // result needs no memory lookup
    logic res_hold;      // park the result until the output frees up
    logic out_load;      // load the output register
    logic out_from_res;  // output register takes the parked result
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_alloc;   // incoming word is an allocate
    logic in_range;   // incoming index addresses a slot
    logic empty;      // no free slot left
  } ctrl_sts_t;

endpackage

// ----- sv/gha_if.sv -----
`timescale 1ns / 1ps
// gha_req_if and gha_rsp_if: valid/ready channels of the allocator
// depends on gha_pkg for the word types

interface gha_req_if;
  logic          valid;
  logic          ready;
  gha_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gha_rsp_if;
  logic          valid;
  logic          ready;
  gha_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/gha_ram.sv -----
`timescale 1ns / 1ps
// gha_ram: generic single-port ram with registered read data
// no dependencies

module gha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one access per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/gha_ctrl.sv -----
`timescale 1ns / 1ps
// gha_ctrl: sequencing state machine of the allocator and output valid
// depends on gha_pkg for the command and status structs

module gha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  gha_pkg::ctrl_sts_t sts_i,
  output gha_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_POP     = 5'b00010,
    S_GRANT   = 5'b00100,
    S_CHECK   = 5'b01000,
    S_DELIVER = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               take;
  logic               out_free;
  logic               produce;
  gha_pkg::ctrl_cmd_t cmd;

  assign req_ready_o = (state_q == S_IDLE);
  assign take        = req_valid_i & req_ready_o;
  assign out_free    = ~out_valid_q | rsp_ready_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    produce = 1'b0;
    cmd.take = take;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          if (sts_i.in_alloc ? sts_i.empty : ~sts_i.in_range) begin
            cmd.direct = 1'b1;
            produce    = 1'b1;
          end else if (sts_i.in_alloc) begin
            state_d = S_POP;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_d = S_GRANT;
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        produce   = 1'b1;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        produce   = 1'b1;
      end
      S_DELIVER: begin
        if (out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_res = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // a finished result goes straight out or waits parked
    if (produce) begin
      if (out_free) begin
        cmd.out_load = 1'b1;
        state_d      = S_IDLE;
      end else begin
        cmd.res_hold = 1'b1;
        state_d      = S_DELIVER;
      end
    end
  end

  // output valid follows loads and takes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // a pop is always followed by its grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> state_q == S_GRANT)
    else $error("pop not followed by grant");

  // a waiting word is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("output word overwritten");

  // a word that needs a lookup blocks the next accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !cmd.direct) |=> !take)
    else $error("accept while a word is in flight");

endmodule

// ----- sv/gha_dp.sv -----
`timescale 1ns / 1ps
// gha_dp: free stack, slot table, counters and result registers of the allocator
// depends on gha_pkg and gha_ram

module gha_dp #(
  parameter int unsigned SLOTS    = gha_pkg::SLOTS_DEF,
  parameter int unsigned GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gha_pkg::ctrl_cmd_t cmd_i,
  output gha_pkg::ctrl_sts_t sts_o,
  input  gha_pkg::req_t      req_i,
  output gha_pkg::rsp_t      rsp_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // free count and low-water mark of the free count; slots at or above the
  // mark have been handed out at least once, stack positions below it still
  // hold their reset value
  logic [CW-1:0] fc_q, fc_d;
  logic [CW-1:0] mark_q, mark_d;

  // request held for the lookup
  logic [gha_pkg::CMD_W-1:0] cmd_q;
  logic [gha_pkg::IDX_W-1:0] idx_q;
  logic [gha_pkg::GEN_W-1:0] gen_q;
  logic [IW-1:0]             slot_sel_q;
  logic                      fresh_q;

  gha_pkg::rsp_t res_q, res_d, out_q;

  logic [CW-1:0]       top_w;
  logic [IW-1:0]       top_pos;
  logic                top_fresh;
  logic [IW-1:0]       pop_slot;
  logic [IW-1:0]       idx_addr;
  logic [IW-1:0]       in_addr;

  logic                stk_we;
  logic [IW-1:0]       stk_addr;
  logic [IW-1:0]       stk_rdata;
  logic                slt_we;
  logic [IW-1:0]       slt_addr;
  logic [GEN_BITS:0]   slt_wdata;
  logic [GEN_BITS:0]   slt_rdata;

  logic [GEN_BITS-1:0] grant_gen;
  logic                touched;
  logic [GEN_BITS-1:0] cur_gen;
  logic                handle_ok;
  logic                do_release;
  logic                push_ok;
  logic [GEN_BITS-1:0] next_gen;

  // status of the incoming word
  assign in_addr        = IW'(req_i.slot_index);
  assign sts_o.in_alloc = (req_i.command == gha_pkg::CMD_ALLOC);
  assign sts_o.in_range = (32'(req_i.slot_index) < 32'(SLOTS));
  assign sts_o.empty    = (fc_q == '0);

  // top of stack and what a pop yields
  assign top_w     = fc_q - CW'(1);
  assign top_pos   = top_w[IW-1:0];
  assign top_fresh = (CW'(top_pos) < mark_q);
  assign pop_slot  = top_fresh ? top_pos : stk_rdata;
  assign idx_addr  = IW'(idx_q);

  // allocate: generation of the popped slot
  assign grant_gen = fresh_q ? '0 : slt_rdata[GEN_BITS-1:0];

  // release and check: handle test
  assign touched    = (CW'(idx_addr) >= mark_q);
  assign cur_gen    = touched ? slt_rdata[GEN_BITS-1:0] : '0;
  assign handle_ok  = touched & slt_rdata[GEN_BITS] & (32'(cur_gen) == 32'(gen_q));
  assign do_release = cmd_i.check & handle_ok & (cmd_q == gha_pkg::CMD_RELEASE);
  assign push_ok    = (fc_q < CW'(SLOTS));
  assign next_gen   = GEN_BITS'(cur_gen + 1'b1);

  // free stack port
  assign stk_we   = do_release & push_ok;
  assign stk_addr = cmd_i.take ? top_pos : fc_q[IW-1:0];

  // slot table port: occupied flag over generation
  always_comb begin
    slt_we    = 1'b0;
    slt_addr  = idx_addr;
    slt_wdata = {1'b0, next_gen};
    if (cmd_i.take) begin
      slt_addr = in_addr;
    end else if (cmd_i.pop) begin
      slt_addr = pop_slot;
    end else if (cmd_i.grant) begin
      slt_we    = 1'b1;
      slt_addr  = slot_sel_q;
      slt_wdata = {1'b1, grant_gen};
    end else if (do_release) begin
      slt_we = 1'b1;
    end
  end

  gha_ram #(
    .Width (IW),
    .Depth (SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (idx_addr),
    .rdata_o (stk_rdata)
  );

  gha_ram #(
    .Width (GEN_BITS + 1),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slt_we),
    .addr_i  (slt_addr),
    .wdata_i (slt_wdata),
    .rdata_o (slt_rdata)
  );

  // free count and mark
  always_comb begin
    fc_d   = fc_q;
    mark_d = mark_q;
    if (cmd_i.pop) begin
      fc_d = top_w;
      if (top_fresh) begin
        mark_d = CW'(top_pos);
      end
    end else if (stk_we) begin
      fc_d = fc_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= CW'(SLOTS);
      mark_q <= CW'(SLOTS);
    end else begin
      fc_q   <= fc_d;
      mark_q <= mark_d;
    end
  end

  // result word
  always_comb begin
    res_d = '0;
    if (cmd_i.direct) begin
      if (sts_o.in_alloc) begin
        res_d.status = gha_pkg::ST_FULL;
      end else begin
        res_d.status        = gha_pkg::ST_INVALID;
        res_d.granted_index = req_i.slot_index;
      end
    end else if (cmd_i.grant) begin
      res_d.status             = gha_pkg::ST_OK;
      res_d.granted_index      = gha_pkg::IDX_W'(slot_sel_q);
      res_d.granted_generation = gha_pkg::GEN_W'(grant_gen);
    end else begin
      res_d.status             = handle_ok ? gha_pkg::ST_OK : gha_pkg::ST_INVALID;
      res_d.granted_index      = idx_q;
      res_d.granted_generation = gha_pkg::GEN_W'(do_release ? next_gen : cur_gen);
    end
  end

  // request, popped slot and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q <= req_i.command;
      idx_q <= req_i.slot_index;
      gen_q <= req_i.handle_generation;
    end
    if (cmd_i.pop) begin
      slot_sel_q <= pop_slot;
      fresh_q    <= (CW'(pop_slot) < mark_q);
    end
    if (cmd_i.res_hold) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= cmd_i.out_from_res ? res_q : res_d;
    end
  end

  assign rsp_o = out_q;

  // free count stays within the stack and the mark at or below it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CW'(SLOTS) && mark_q <= fc_q)
    else $error("free count or mark out of bounds");

  // no pop from an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> fc_q != '0)
    else $error("pop from empty stack");

  // an occupied slot always finds room on the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_release |-> push_ok)
    else $error("release onto a full stack");

endmodule

// ----- sv/generational_handle_allocator_top.sv -----
`timescale 1ns / 1ps
// Generational handle allocator: one result word per request word.
// Release and check: table read at accept, then tested, updated on release; no overlap.
// Allocate: stack read at accept, then table read, then table write; no overlap.
// Allocate when full, release or check out of range: result at the accept edge, no lookup.
// A stalled output parks one result and holds off requests until it moves on.
// Async active-low reset, ready at once: a low-water mark replaces a clearing pass.

module generational_handle_allocator_top #(
  parameter int unsigned SLOTS    = gha_pkg::SLOTS_DEF,
  parameter int unsigned GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gha_req_if.sink   req_i,
  gha_rsp_if.source rsp_o
);

  gha_pkg::ctrl_cmd_t cmd;
  gha_pkg::ctrl_sts_t sts;
  logic               req_ready;
  logic               rsp_valid;
  gha_pkg::rsp_t      rsp_word;

  // sequencing
  gha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stack, slot table and result word
  gha_dp #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i.payload),
    .rsp_o  (rsp_word)
  );

  assign req_i.ready   = req_ready;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_word;

endmodule
